// ===== rtl/lock_order_cycle_checker_unit_defines.svh =====
// assertion macros used by locc_back
`ifndef LOCK_ORDER_CYCLE_CHECKER_UNIT_DEFINES_SVH
`define LOCK_ORDER_CYCLE_CHECKER_UNIT_DEFINES_SVH

// same-cycle implication
`define LOCC_ASSERT_NOW(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |-> (c)) else $error("lock order checker assertion failed");

// next-cycle implication
`define LOCC_ASSERT_NEXT(lbl, a, c) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (a) |=> (c)) else $error("lock order checker assertion failed");

`endif

// ===== rtl/locc_pkg.sv =====
package locc_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOT_TOP  = 3'd2;
  localparam logic [2:0] ST_DEADLOCK = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [3:0] lock_num;
  } item_t;

endpackage

// ===== rtl/lock_order_cycle_checker_unit.sv =====
// lock order checker for one context: each acquire/release transaction updates a held
// stack; an acquire that adds a new edge top->id to the lock order graph starts a
// depth-first search for a back edge, reported as a deadlock with that edge. releases,
// overflow and acquires that add no edge complete without a search; a search steps
// through each root slot in turn, then each edge step and node finish of the dfs
// engine, until a back edge is found or all roots are done. a two-entry queue
// decouples input acceptance from the search engine.
module lock_order_cycle_checker_unit #(
  parameter int MAX_LOCKS  = 16,
  parameter int HELD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [3:0] in_lock_num,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_status,
  output logic [3:0] out_cycle_from,
  output logic [3:0] out_cycle_to,
  output logic [4:0] out_held_count
);
  import locc_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  locc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_lock_num,
    .q_valid, .q_item, .q_pop
  );

  locc_back #(.MAX_LOCKS(MAX_LOCKS), .HELD_DEPTH(HELD_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .out_status, .out_cycle_from, .out_cycle_to, .out_held_count
  );

endmodule

// ===== rtl/locc_front.sv =====
module locc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [3:0]          in_lock_num,
  output logic                q_valid,
  output locc_pkg::item_t     q_item,
  input  logic                q_pop
);
  import locc_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{req_type: in_req_type, lock_num: in_lock_num};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/locc_back.sv =====
`include "lock_order_cycle_checker_unit_defines.svh"
module locc_back #(
  parameter int MAX_LOCKS  = 16,
  parameter int HELD_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  locc_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [3:0]          out_cycle_from,
  output logic [3:0]          out_cycle_to,
  output logic [4:0]          out_held_count
);
  import locc_pkg::*;

  localparam int NW = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
  localparam int CW = $clog2(MAX_LOCKS + 1);
  localparam int HW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int DW = $clog2(HELD_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ROOT = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;

  logic [1:0]           state_r;
  logic [MAX_LOCKS-1:0] edges_r [MAX_LOCKS];
  logic [3:0]           held_r [HELD_DEPTH];
  logic [DW-1:0]        depth_r;
  logic [MAX_LOCKS-1:0] visited_r, finished_r;
  logic [NW-1:0]        rank_r [MAX_LOCKS];
  logic [NW-1:0]        snode_r [MAX_LOCKS];
  logic [CW-1:0]        scur_r [MAX_LOCKS];
  logic [CW-1:0]        sp_r, root_r, nrank_r;
  logic [3:0]           pend_id_r;
  logic                 out_valid_r;
  logic [2:0]           status_r;
  logic [3:0]           from_r, to_r;
  logic [4:0]           count_r;

  logic [3:0]    top_id;
  logic [NW-1:0] top_ix, id_ix, fr, node, nb, root_ix;
  logic [CW-1:0] cur;
  logic          found, new_edge;
  logic [MAX_LOCKS-1:0] row;

  assign q_pop          = (state_r == S_IDLE) && q_valid && !out_valid_r;
  assign top_id         = held_r[HW'(depth_r - 1'b1)];
  assign top_ix         = NW'(top_id);
  assign id_ix          = NW'(q_item.lock_num);
  assign new_edge       = (depth_r != '0) && (top_id != q_item.lock_num)
                       && (7'(top_id) < 7'(MAX_LOCKS)) && (7'(q_item.lock_num) < 7'(MAX_LOCKS))
                       && !edges_r[top_ix][id_ix];
  assign fr             = NW'(sp_r - 1'b1);
  assign node           = snode_r[fr];
  assign cur            = scur_r[fr];
  assign row            = edges_r[node];
  assign root_ix        = NW'(root_r);

  always_comb begin
    found = 1'b0;
    nb    = '0;
    for (int i = 0; i < MAX_LOCKS; i++) begin
      if (!found && row[i] && (CW'(i) >= cur)) begin
        found = 1'b1;
        nb    = NW'(i);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_cycle_from = from_r;
  assign out_cycle_to   = to_r;
  assign out_held_count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_LOCKS; i++) edges_r[i] <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            from_r      <= '0;
            to_r        <= '0;
            status_r    <= ST_OK;
            count_r     <= 5'(depth_r);
            out_valid_r <= 1'b1;
            if (q_item.req_type == REQ_RELEASE) begin
              if (depth_r == '0) begin
                status_r <= ST_EMPTY;
              end else if (top_id != q_item.lock_num) begin
                status_r <= ST_NOT_TOP;
              end else begin
                depth_r <= depth_r - 1'b1;
                count_r <= 5'(depth_r - 1'b1);
              end
            end else if (32'(depth_r) >= HELD_DEPTH) begin
              status_r <= ST_OVERFLOW;
            end else if (new_edge) begin
              edges_r[top_ix][id_ix] <= 1'b1;
              out_valid_r <= 1'b0;
              pend_id_r   <= q_item.lock_num;
              visited_r   <= '0;
              finished_r  <= '0;
              nrank_r     <= '0;
              root_r      <= '0;
              state_r     <= S_ROOT;
            end else begin
              held_r[HW'(depth_r)] <= q_item.lock_num;
              depth_r <= depth_r + 1'b1;
              count_r <= 5'(depth_r + 1'b1);
            end
          end
        end
        S_ROOT: begin
          if (root_r == CW'(MAX_LOCKS)) begin
            held_r[HW'(depth_r)] <= pend_id_r;
            depth_r     <= depth_r + 1'b1;
            status_r    <= ST_OK;
            from_r      <= '0;
            to_r        <= '0;
            count_r     <= 5'(depth_r + 1'b1);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (visited_r[root_ix]) begin
            root_r <= root_r + 1'b1;
          end else begin
            visited_r[root_ix] <= 1'b1;
            rank_r[root_ix]    <= NW'(nrank_r);
            nrank_r            <= nrank_r + 1'b1;
            snode_r[0]         <= root_ix;
            scur_r[0]          <= '0;
            sp_r               <= CW'(1);
            state_r            <= S_STEP;
          end
        end
        S_STEP: begin
          if (!found) begin
            finished_r[node] <= 1'b1;
            sp_r <= sp_r - 1'b1;
            if (sp_r == CW'(1)) begin
              root_r  <= root_r + 1'b1;
              state_r <= S_ROOT;
            end
          end else begin
            scur_r[fr] <= CW'(nb) + 1'b1;
            if (!visited_r[nb]) begin
              visited_r[nb] <= 1'b1;
              rank_r[nb]    <= NW'(nrank_r);
              nrank_r       <= nrank_r + 1'b1;
              if (sp_r < CW'(MAX_LOCKS)) begin
                snode_r[NW'(sp_r)] <= nb;
                scur_r[NW'(sp_r)]  <= '0;
                sp_r <= sp_r + 1'b1;
              end
            end else if (!(rank_r[node] < rank_r[nb]) && !finished_r[nb]) begin
              status_r    <= ST_DEADLOCK;
              from_r      <= 4'(node);
              to_r        <= 4'(nb);
              count_r     <= 5'(depth_r);
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `LOCC_ASSERT_NOW(a_no_pop_busy, state_r != S_IDLE, !q_pop)
  `LOCC_ASSERT_NOW(a_sp_range, state_r == S_STEP, (sp_r != '0) && (sp_r <= CW'(MAX_LOCKS)))
  `LOCC_ASSERT_NEXT(a_deadlock_from_step, !out_valid_r && !$past(1'b0) && 1'b1,
    !(out_valid_r && status_r == ST_DEADLOCK) || $past(state_r) == S_STEP)
  `LOCC_ASSERT_NOW(a_no_out_in_search, state_r != S_IDLE, !out_valid_r)

endmodule
